>>> hw/rtl/ags_pkg.sv
// ============================================================================
// ags_pkg
// Shared types, constants and helpers for the alignment group spread block.
// ============================================================================
package ags_pkg;

    // Default parameter values
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths
    localparam int BASES_W = 32;
    localparam int ALIGN_W = BASES_W + 2;
    localparam int VALUE_W = 17;
    localparam int EXT_W   = 33;
    localparam int CFG_W   = 2;
    localparam int IDX_W   = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // Metric selection
    localparam logic [1:0] MODE_COUNT = 2'd0;
    localparam logic [1:0] MODE_COV   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MULTI   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_NONZERO = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sum;
        logic check;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic trivial;
        logic stall;
    } dp_stat_t;

    // Clip a widened result to the output field
    function automatic logic [VALUE_W-1:0] clip_value(input logic [EXT_W-1:0] v);
        logic [VALUE_W-1:0] r;
        if (v > EXT_W'(VALUE_MAX))
            r = VALUE_MAX;
        else
            r = v[VALUE_W-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/alignment_group_spread.sv
// ============================================================================
// alignment_group_spread
// Per-query record count, coverage spread or identity spread.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | match_bases mismatch_bases repeat_bases
//          |                       | query_size group_end
//  out     | out_valid / out_ready | value count_saturated
//  cfg     | cfg_we                | cfg_index cfg_data
//
//  A request steps through idle, sum, check, divide and finish before the next
//  is accepted; the radix-2 divider gives one quotient bit a cycle, and count
//  mode and ratios of zero or at least one skip the divide state.
//  The last record of a group waits in its final cycle while an earlier result
//  is still untaken; other records never wait on the output.
//  Reset clears the configuration, the group state and the output valid flag.
//
module alignment_group_spread
    import ags_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BASES_W-1:0] match_bases,
    input  logic [BASES_W-1:0] mismatch_bases,
    input  logic [BASES_W-1:0] repeat_bases,
    input  logic [BASES_W-1:0] query_size,
    input  logic               group_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value,
    output logic               count_saturated
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    ags_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    ags_dp #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .match_bases     (match_bases),
        .mismatch_bases  (mismatch_bases),
        .repeat_bases    (repeat_bases),
        .query_size      (query_size),
        .group_end       (group_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value           (value),
        .count_saturated (count_saturated),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

>>> hw/rtl/ags_ctrl.sv
// ============================================================================
// ags_ctrl
// Sequencer: accept a request, form operands, run the divider when needed, commit.
// ============================================================================
module ags_ctrl
    import ags_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_last;

    assign div_last = (cnt_reg == CNT_W'(FRAC_BITS - 1));
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.check = 1'b1;
                cnt_next  = '0;
                if (stat.trivial)
                    state_next = S_FIN;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (div_last)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                if (!stat.stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SUM))
        else $error("load did not advance to operand stage");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_last) |=> (state_reg == S_FIN))
        else $error("divider did not finish after its last step");
`endif

endmodule

>>> hw/rtl/ags_dp.sv
// ============================================================================
// ags_dp
// Datapath: operand forming, restoring divider, group min/max/count, output.
// ============================================================================
module ags_dp
    import ags_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [BASES_W-1:0] match_bases,
    input  logic [BASES_W-1:0] mismatch_bases,
    input  logic [BASES_W-1:0] repeat_bases,
    input  logic [BASES_W-1:0] query_size,
    input  logic               group_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value,
    output logic               count_saturated,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat
);

    localparam int MET_W = FRAC_BITS + 1;
    localparam logic [MET_W-1:0] ONE = MET_W'(1) << FRAC_BITS;

    logic [1:0]            mode_cfg_reg;
    logic                  multi_reg;
    logic                  nonzero_reg;

    logic [BASES_W-1:0]    match_reg, mis_reg, rep_reg, qsize_reg;
    logic                  last_reg;
    logic [1:0]            mode_reg;

    logic [ALIGN_W-1:0]    num_reg, den_reg, rem_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic                  special_reg, one_reg;

    logic [MET_W-1:0]      min_reg, max_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  over_reg;

    logic [VALUE_W-1:0]    value_reg;
    logic                  sat_reg;
    logic                  out_valid_reg;

    logic [ALIGN_W-1:0]    aligned, num_next, den_next;
    logic                  triv_zero, triv_one;
    logic [ALIGN_W:0]      shifted, diff;
    logic                  ge;
    logic [MET_W-1:0]      metric, min_new, max_new, spread;
    logic                  count_full, over_new, emit, spread_mode;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [VALUE_W-1:0]    result;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg <= MODE_COUNT;
            multi_reg    <= 1'b0;
            nonzero_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    mode_cfg_reg <= cfg_data;
                CFG_MULTI:   multi_reg    <= cfg_data[0];
                CFG_NONZERO: nonzero_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            match_reg <= match_bases;
            mis_reg   <= mismatch_bases;
            rep_reg   <= repeat_bases;
            qsize_reg <= query_size;
            last_reg  <= group_end;
            mode_reg  <= mode_cfg_reg;
        end
    end

    // Form numerator and denominator for the selected metric
    always_comb
    begin
        aligned = ALIGN_W'(match_reg) + ALIGN_W'(mis_reg) + ALIGN_W'(rep_reg);
        case (mode_reg)
            MODE_COV:
            begin
                num_next = aligned;
                den_next = ALIGN_W'(qsize_reg);
            end
            MODE_IDENT:
            begin
                num_next = ALIGN_W'(match_reg) + ALIGN_W'(rep_reg);
                den_next = aligned;
            end
            default:
            begin
                num_next = '0;
                den_next = '0;
            end
        endcase
    end

    // Short-cut cases: zero numerator, zero denominator, or a ratio at or above one
    assign triv_zero    = (num_reg == '0);
    assign triv_one     = (den_reg == '0) || (num_reg >= den_reg);
    assign stat.trivial = triv_zero || triv_one;

    // One restoring step
    assign shifted = {rem_reg, 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (cmd.check)
        begin
            special_reg <= triv_zero || triv_one;
            one_reg     <= !triv_zero && triv_one;
            rem_reg     <= num_reg;
            quo_reg     <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? diff[ALIGN_W-1:0] : shifted[ALIGN_W-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    // Group update and result
    always_comb
    begin
        if (special_reg)
            metric = one_reg ? ONE : '0;
        else
            metric = MET_W'(quo_reg);
        min_new     = (metric < min_reg) ? metric : min_reg;
        max_new     = (metric > max_reg) ? metric : max_reg;
        spread      = max_new - min_new;
        count_full  = (count_reg == '1);
        cnt_new     = count_full ? count_reg : count_reg + 1'b1;
        over_new    = over_reg || count_full;
        spread_mode = (mode_reg == MODE_COV) || (mode_reg == MODE_IDENT);
        result      = spread_mode ? clip_value(EXT_W'(spread)) : clip_value(EXT_W'(cnt_new));
        emit        = !(multi_reg && (cnt_new < COUNT_BITS'(2)) && !over_new)
                      && !(nonzero_reg && (result == '0));
    end

    // Hold the last record until the previous result is taken
    assign stat.stall = last_reg && out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '1;
            max_reg   <= '0;
            count_reg <= '0;
            over_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                min_reg   <= '1;
                max_reg   <= '0;
                count_reg <= '0;
                over_reg  <= 1'b0;
            end
            else
            begin
                min_reg   <= min_new;
                max_reg   <= max_new;
                count_reg <= cnt_new;
                over_reg  <= over_new;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit && last_reg && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && last_reg && emit)
        begin
            value_reg <= result;
            sat_reg   <= over_new;
        end
    end

    assign out_valid       = out_valid_reg;
    assign value           = value_reg;
    assign count_saturated = sat_reg;

`ifndef NO_ASSERTIONS
    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (max_reg >= min_reg))
        else $error("group maximum below minimum");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    a_no_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !last_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("result raised on a record inside a group");
`endif

endmodule
